>>> rtl/pl0_pkg.sv
// pl0_pkg: shared types and constants for the p-code stack machine
// used by pl0_ctrl, pl0_dp and pl0_pcode_stack_machine
package pl0_pkg;

  localparam int unsigned StackDepth = 1024;
  localparam int unsigned StackAw    = $clog2(StackDepth);
  localparam int unsigned TopW       = StackAw + 1;
  localparam int unsigned CodeDepth  = 1024;
  localparam int unsigned PcW        = $clog2(CodeDepth);
  localparam int unsigned MaxLevel   = 15;
  localparam int unsigned LevW       = 4;

  localparam logic [2:0] FnLit  = 3'd0;
  localparam logic [2:0] FnLod  = 3'd1;
  localparam logic [2:0] FnSto  = 3'd2;
  localparam logic [2:0] FnCal  = 3'd3;
  localparam logic [2:0] FnInt  = 3'd4;
  localparam logic [2:0] FnJmp  = 3'd5;
  localparam logic [2:0] FnJpc  = 3'd6;
  localparam logic [2:0] FnOpr  = 3'd7;

  localparam logic [31:0] OpRet = 32'd0;
  localparam logic [31:0] OpNeg = 32'd1;
  localparam logic [31:0] OpAdd = 32'd2;
  localparam logic [31:0] OpSub = 32'd3;
  localparam logic [31:0] OpMul = 32'd4;
  localparam logic [31:0] OpDiv = 32'd5;
  localparam logic [31:0] OpEq  = 32'd6;
  localparam logic [31:0] OpNe  = 32'd7;
  localparam logic [31:0] OpLt  = 32'd8;
  localparam logic [31:0] OpGe  = 32'd9;
  localparam logic [31:0] OpGt  = 32'd10;
  localparam logic [31:0] OpLe  = 32'd11;
  localparam logic [31:0] OpWrt = 32'd12;
  localparam logic [31:0] OpNl  = 32'd13;
  localparam logic [31:0] OpRd  = 32'd14;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StBadOp = 2'd1;
  localparam logic [1:0] StStack = 2'd2;
  localparam logic [1:0] StDiv0  = 2'd3;

  localparam logic [1:0] PkNone  = 2'd0;
  localparam logic [1:0] PkValue = 2'd1;
  localparam logic [1:0] PkNl    = 2'd2;

  typedef struct packed {
    logic [2:0]         op_function;
    logic [3:0]         op_level;
    logic signed [31:0] op_argument;
    logic signed [31:0] read_value;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         next_pc;
    logic [1:0]         print_kind;
    logic signed [31:0] print_value;
    logic               halted;
    logic [1:0]         status;
  } out_item_t;

  // datapath memory port / unit selects
  typedef enum logic [2:0] {
    RaTopM1 = 3'd0,  // t-1
    RaTopM2 = 3'd1,  // t-2
    RaWalk  = 3'd2,  // walk base
    RaAddr  = 3'd3,  // arg + walk base
    RaBase1 = 3'd4,  // base+1
    RaBase2 = 3'd5,  // base+2
    RaBase0 = 3'd6   // memory clear pointer
  } raddr_sel_e;

  typedef enum logic [2:0] {
    WdArg   = 3'd0,
    WdRdat  = 3'd1,
    WdWalk  = 3'd2,
    WdBase  = 3'd3,
    WdPc    = 3'd4,
    WdAlu   = 3'd5,
    WdRead  = 3'd6,
    WdZero  = 3'd7
  } wdata_sel_e;

  typedef enum logic [2:0] {
    WaTop   = 3'd0,
    WaTopP1 = 3'd1,
    WaTopP2 = 3'd2,
    WaTopM1 = 3'd3,
    WaTopM2 = 3'd4,
    WaAddr  = 3'd5,
    WaClr   = 3'd6
  } waddr_sel_e;

  typedef struct packed {
    logic       load_instr;
    logic       pc_inc;
    logic       rd_en;
    raddr_sel_e rsel;
    logic       wr_en;
    waddr_sel_e wsel;
    wdata_sel_e dsel;
    logic       cap_y;      // rdat -> y
    logic       cap_x;      // rdat -> x
    logic       walk_init;
    logic       walk_hop;   // rdat -> walk base
    logic       top_inc;
    logic       top_dec;
    logic       top_alloc;
    logic       top_to_base;
    logic       call_frame; // base <- t, pc <- arg
    logic       pc_jump;
    logic       ret_base;   // base <- rdat
    logic       ret_pc;     // pc <- rdat
    logic       alu_start;
    logic       clr_step;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0]  fn;
    logic [31:0] arg;
    logic [TopW-1:0] top;
    logic        rdat_zero;
    logic        alu_done;
    logic        div0;
    logic        clr_last;
    logic        alloc_bad;
  } dp_stat_t;

endpackage

>>> rtl/pl0_alu.sv
// pl0_alu: operate unit for the stack machine, directly registered ops plus
// a radix-2 restoring divider (32 steps); uses pl0_pkg
module pl0_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] op_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  output logic        done_o,
  output logic [31:0] res_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d, res_q, res_d;
  logic        neg_q, neg_d, done_q, done_d;
  logic [31:0] mx, my;
  logic        lt_xy, lt_yx;
  logic [32:0] trial;
  logic [63:0] prod;

  assign mx = x_i[31] ? 32'd0 - x_i : x_i;
  assign my = y_i[31] ? 32'd0 - y_i : y_i;
  assign lt_xy = $signed(x_i) < $signed(y_i);
  assign lt_yx = $signed(y_i) < $signed(x_i);
  assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};
  assign prod = x_i * y_i;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    res_d  = res_q;
    done_d = 1'b0;
    if (start_i) begin
      if (op_i == pl0_pkg::OpDiv) begin
        if (y_i == 32'd0) begin
          res_d  = 32'd0;
          done_d = 1'b1;
        end else begin
          busy_d = 1'b1;
          cnt_d  = 6'd0;
          rem_d  = 32'd0;
          quo_d  = mx;
          dvs_d  = my;
          neg_d  = x_i[31] ^ y_i[31];
        end
      end else begin
        done_d = 1'b1;
        case (op_i)
          pl0_pkg::OpAdd: res_d = x_i + y_i;
          pl0_pkg::OpSub: res_d = x_i - y_i;
          pl0_pkg::OpMul: res_d = prod[31:0];
          pl0_pkg::OpEq:  res_d = {31'd0, x_i == y_i};
          pl0_pkg::OpNe:  res_d = {31'd0, x_i != y_i};
          pl0_pkg::OpLt:  res_d = {31'd0, lt_xy};
          pl0_pkg::OpGe:  res_d = {31'd0, !lt_xy};
          pl0_pkg::OpGt:  res_d = {31'd0, lt_yx};
          pl0_pkg::OpNeg: res_d = 32'd0 - y_i;
          default:        res_d = {31'd0, !lt_yx};
        endcase
      end
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = neg_q ? 32'd0 - quo_d : quo_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> rtl/pl0_dp.sv
// pl0_dp: datapath of the stack machine: stack memory, top, base, pc,
// link walk register, operands and operate unit; uses pl0_pkg, pl0_alu
module pl0_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pl0_pkg::in_item_t in_i,
  input  pl0_pkg::dp_cmd_t  cmd_i,
  output pl0_pkg::dp_stat_t stat_o,
  output logic [31:0]       rdat_o,
  output logic [9:0]        pc_o
);

  localparam int unsigned Aw = pl0_pkg::StackAw;
  localparam int unsigned Tw = pl0_pkg::TopW;
  localparam int unsigned Pw = pl0_pkg::PcW;

  logic [31:0] mem [pl0_pkg::StackDepth];
  logic [31:0] rdat_q;
  pl0_pkg::in_item_t ins_q;
  logic [Tw-1:0] top_q;
  logic [Aw-1:0] base_q, walk_q, clr_q;
  logic [Pw-1:0] pc_q;
  logic [31:0] x_q, y_q;
  logic [Aw-1:0] raddr, waddr, top_a, addr;
  logic [31:0] wdata, alu_res;
  logic [Tw+31:0] alloc_sum;
  logic alu_done;
  logic alloc_bad;

  assign top_a = top_q[Aw-1:0];
  assign addr  = ins_q.op_argument[Aw-1:0] + walk_q;
  assign alloc_sum = {{32{1'b0}}, top_q} + {{Tw{ins_q.op_argument[31]}}, ins_q.op_argument};

  always_comb begin
    case (cmd_i.rsel)
      pl0_pkg::RaTopM1: raddr = top_a - Aw'(1);
      pl0_pkg::RaTopM2: raddr = top_a - Aw'(2);
      pl0_pkg::RaWalk:  raddr = walk_q;
      pl0_pkg::RaAddr:  raddr = addr;
      pl0_pkg::RaBase1: raddr = base_q + Aw'(1);
      pl0_pkg::RaBase2: raddr = base_q + Aw'(2);
      default:          raddr = clr_q;
    endcase
    case (cmd_i.wsel)
      pl0_pkg::WaTop:   waddr = top_a;
      pl0_pkg::WaTopP1: waddr = top_a + Aw'(1);
      pl0_pkg::WaTopP2: waddr = top_a + Aw'(2);
      pl0_pkg::WaTopM1: waddr = top_a - Aw'(1);
      pl0_pkg::WaTopM2: waddr = top_a - Aw'(2);
      pl0_pkg::WaAddr:  waddr = addr;
      default:          waddr = clr_q;
    endcase
    case (cmd_i.dsel)
      pl0_pkg::WdArg:  wdata = ins_q.op_argument;
      pl0_pkg::WdRdat: wdata = rdat_q;
      pl0_pkg::WdWalk: wdata = 32'(walk_q);
      pl0_pkg::WdBase: wdata = 32'(base_q);
      pl0_pkg::WdPc:   wdata = 32'(pc_q);
      pl0_pkg::WdAlu:  wdata = alu_res;
      pl0_pkg::WdRead: wdata = ins_q.read_value;
      default:         wdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[waddr] <= wdata;
    if (cmd_i.rd_en) rdat_q <= mem[raddr];
    if (cmd_i.load_instr) ins_q <= in_i;
    if (cmd_i.cap_x) x_q <= rdat_q;
    if (cmd_i.cap_y) y_q <= rdat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= '0;
      base_q <= '0;
      pc_q   <= '0;
      walk_q <= '0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + Aw'(1);
      if (cmd_i.walk_init) walk_q <= base_q;
      else if (cmd_i.walk_hop) walk_q <= rdat_q[Aw-1:0];
      if (cmd_i.pc_inc) pc_q <= pc_q + Pw'(1);
      else if (cmd_i.call_frame || cmd_i.pc_jump) pc_q <= ins_q.op_argument[Pw-1:0];
      else if (cmd_i.ret_pc) pc_q <= rdat_q[Pw-1:0];
      if (cmd_i.top_inc) top_q <= top_q + Tw'(1);
      else if (cmd_i.top_dec) top_q <= top_q - Tw'(1);
      else if (cmd_i.top_alloc) top_q <= alloc_sum[Tw-1:0];
      else if (cmd_i.top_to_base) top_q <= {1'b0, base_q};
      if (cmd_i.call_frame) base_q <= top_a;
      else if (cmd_i.ret_base) base_q <= rdat_q[Aw-1:0];
    end
  end

  pl0_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.alu_start),
    .op_i   (ins_q.op_argument),
    .x_i    (x_q),
    .y_i    (y_q),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  // alloc fault: result below zero or above depth
  assign alloc_bad = alloc_sum[Tw+31] || (alloc_sum[Tw+30:0] > (Tw+31)'(pl0_pkg::StackDepth));

  assign stat_o.fn        = ins_q.op_function;
  assign stat_o.arg       = ins_q.op_argument;
  assign stat_o.top       = top_q;
  assign stat_o.rdat_zero = (rdat_q == 32'd0);
  assign stat_o.alu_done  = alu_done;
  assign stat_o.div0      = (y_q == 32'd0);
  assign stat_o.clr_last  = (clr_q == Aw'(pl0_pkg::StackDepth - 1));
  assign stat_o.alloc_bad = alloc_bad;
  assign rdat_o = rdat_q;
  assign pc_o   = 10'(pc_q);

endmodule

>>> rtl/pl0_ctrl.sv
// pl0_ctrl: sequencer for the stack machine; drives pl0_dp commands
// and the input/output handshakes; uses pl0_pkg
module pl0_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [3:0]        in_level_i,
  input  logic [2:0]        in_fn_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pl0_pkg::out_item_t out_o,
  output pl0_pkg::dp_cmd_t  cmd_o,
  input  pl0_pkg::dp_stat_t stat_i,
  input  logic [31:0]       rdat_i,
  input  logic [9:0]        pc_i
);

  typedef enum logic [9:0] {
    SClr  = 10'b0000000001,
    SIdle = 10'b0000000010,
    SDec  = 10'b0000000100,
    SWalk = 10'b0000001000,
    SAct  = 10'b0000010000,
    SRd1  = 10'b0000100000,
    SRd2  = 10'b0001000000,
    SAlu  = 10'b0010000000,
    SFin  = 10'b0100000000,
    SOut  = 10'b1000000000
  } state_e;

  localparam int unsigned Tw = pl0_pkg::TopW;
  localparam logic [Tw-1:0] Depth = Tw'(pl0_pkg::StackDepth);

  state_e state_q, state_d;
  logic [3:0] hops_q, hops_d;
  logic [1:0] kind_q, kind_d, st_q, st_d;
  logic [31:0] pval_q, pval_d;
  logic [1:0] ph_q, ph_d;
  logic out_v_q, out_v_d;
  pl0_pkg::out_item_t res_q, res_d;

  logic [2:0]  fn;
  logic [31:0] arg;
  logic [Tw-1:0] t;
  logic arith, need1, need2, full;

  assign fn  = stat_i.fn;
  assign arg = stat_i.arg;
  assign t   = stat_i.top;
  assign arith = (arg >= pl0_pkg::OpAdd) && (arg <= pl0_pkg::OpLe);
  assign need1 = (t == '0) || (t > Depth);
  assign need2 = (t < Tw'(2)) || (t > Depth);
  assign full  = (t >= Depth);

  assign in_ready_o  = (state_q == SIdle) && !out_v_q;
  assign out_valid_o = out_v_q;
  assign out_o       = res_q;

  always_comb begin
    state_d = state_q;
    hops_d  = hops_q;
    kind_d  = kind_q;
    st_d    = st_q;
    pval_d  = pval_q;
    ph_d    = ph_q;
    out_v_d = out_v_q;
    res_d   = res_q;
    cmd_o   = '0;
    if (out_v_q && out_ready_i) out_v_d = 1'b0;
    case (state_q)
      SClr: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = pl0_pkg::WaClr;
        cmd_o.dsel  = pl0_pkg::WdZero;
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = SIdle;
      end
      SIdle: begin
        if (in_valid_i && !out_v_q) begin
          cmd_o.load_instr = 1'b1;
          cmd_o.pc_inc     = 1'b1;
          cmd_o.walk_init  = 1'b1;
          hops_d = (in_level_i > 4'(pl0_pkg::MaxLevel)) ? 4'(pl0_pkg::MaxLevel) : in_level_i;
          if (!(in_fn_i == pl0_pkg::FnLod || in_fn_i == pl0_pkg::FnSto ||
                in_fn_i == pl0_pkg::FnCal)) hops_d = 4'd0;
          kind_d = pl0_pkg::PkNone;
          st_d   = pl0_pkg::StOk;
          pval_d = 32'd0;
          ph_d   = 2'd0;
          state_d = SDec;
        end
      end
      SDec: begin
        // issue link read for the walk while hops remain, else go act
        if (hops_q != 4'd0) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rsel  = pl0_pkg::RaWalk;
          state_d = SWalk;
        end else begin
          state_d = SAct;
        end
      end
      SWalk: begin
        cmd_o.walk_hop = 1'b1;
        hops_d = hops_q - 4'd1;
        state_d = SDec;
      end
      SAct: begin
        state_d = SFin;
        case (fn)
          pl0_pkg::FnLit: begin
            if (full) st_d = pl0_pkg::StStack;
            else begin
              cmd_o.wr_en = 1'b1; cmd_o.wsel = pl0_pkg::WaTop;
              cmd_o.dsel = pl0_pkg::WdArg; cmd_o.top_inc = 1'b1;
            end
          end
          pl0_pkg::FnLod: begin
            if (full) st_d = pl0_pkg::StStack;
            else begin
              cmd_o.rd_en = 1'b1; cmd_o.rsel = pl0_pkg::RaAddr;
              state_d = SRd1;
            end
          end
          pl0_pkg::FnSto: begin
            if (need1) st_d = pl0_pkg::StStack;
            else begin
              cmd_o.rd_en = 1'b1; cmd_o.rsel = pl0_pkg::RaTopM1;
              state_d = SRd1;
            end
          end
          pl0_pkg::FnCal: begin
            if (t + Tw'(2) >= Depth) st_d = pl0_pkg::StStack;
            else begin
              // three link words, one per cycle
              cmd_o.wr_en = 1'b1;
              case (ph_q)
                2'd0: begin
                  cmd_o.wsel = pl0_pkg::WaTop; cmd_o.dsel = pl0_pkg::WdWalk;
                  ph_d = 2'd1; state_d = SAct;
                end
                2'd1: begin
                  cmd_o.wsel = pl0_pkg::WaTopP1; cmd_o.dsel = pl0_pkg::WdBase;
                  ph_d = 2'd2; state_d = SAct;
                end
                default: begin
                  cmd_o.wsel = pl0_pkg::WaTopP2; cmd_o.dsel = pl0_pkg::WdPc;
                  cmd_o.call_frame = 1'b1;
                end
              endcase
            end
          end
          pl0_pkg::FnInt: begin
            if (stat_i.alloc_bad) st_d = pl0_pkg::StStack;
            else cmd_o.top_alloc = 1'b1;
          end
          pl0_pkg::FnJmp: cmd_o.pc_jump = 1'b1;
          pl0_pkg::FnJpc: begin
            if (need1) st_d = pl0_pkg::StStack;
            else begin
              cmd_o.rd_en = 1'b1; cmd_o.rsel = pl0_pkg::RaTopM1;
              state_d = SRd1;
            end
          end
          default: begin
            if (arg == pl0_pkg::OpRet) begin
              cmd_o.rd_en = 1'b1; cmd_o.rsel = pl0_pkg::RaBase1;
              state_d = SRd1;
            end else if (arg == pl0_pkg::OpNeg || arg == pl0_pkg::OpWrt) begin
              if (need1) st_d = pl0_pkg::StStack;
              else begin
                cmd_o.rd_en = 1'b1; cmd_o.rsel = pl0_pkg::RaTopM1;
                state_d = SRd1;
              end
            end else if (arith) begin
              if (need2) st_d = pl0_pkg::StStack;
              else begin
                cmd_o.rd_en = 1'b1; cmd_o.rsel = pl0_pkg::RaTopM1;
                state_d = SRd1;
              end
            end else if (arg == pl0_pkg::OpNl) begin
              kind_d = pl0_pkg::PkNl;
            end else if (arg == pl0_pkg::OpRd) begin
              if (full) st_d = pl0_pkg::StStack;
              else begin
                cmd_o.wr_en = 1'b1; cmd_o.wsel = pl0_pkg::WaTop;
                cmd_o.dsel = pl0_pkg::WdRead; cmd_o.top_inc = 1'b1;
              end
            end else begin
              st_d = pl0_pkg::StBadOp;
            end
          end
        endcase
      end
      SRd1: begin
        state_d = SFin;
        case (fn)
          pl0_pkg::FnLod: begin
            cmd_o.wr_en = 1'b1; cmd_o.wsel = pl0_pkg::WaTop;
            cmd_o.dsel = pl0_pkg::WdRdat; cmd_o.top_inc = 1'b1;
          end
          pl0_pkg::FnSto: begin
            cmd_o.wr_en = 1'b1; cmd_o.wsel = pl0_pkg::WaAddr;
            cmd_o.dsel = pl0_pkg::WdRdat; cmd_o.top_dec = 1'b1;
          end
          pl0_pkg::FnJpc: begin
            if (stat_i.rdat_zero) cmd_o.pc_jump = 1'b1;
          end
          default: begin
            if (arg == pl0_pkg::OpRet) begin
              // rdat = old base+1 word; fetch return address next
              // base+2 address and top still see the old base this cycle
              cmd_o.cap_x = 1'b1;
              cmd_o.ret_base = 1'b1;
              cmd_o.rd_en = 1'b1; cmd_o.rsel = pl0_pkg::RaBase2;
              cmd_o.top_to_base = 1'b1;
              state_d = SRd2;
            end else if (arg == pl0_pkg::OpWrt) begin
              kind_d = pl0_pkg::PkValue;
              pval_d = rdat_i;
            end else if (arg == pl0_pkg::OpNeg) begin
              cmd_o.cap_y = 1'b1;
              cmd_o.cap_x = 1'b1;
              state_d = SAlu;
              ph_d = 2'd0;
            end else begin
              cmd_o.cap_y = 1'b1;
              cmd_o.rd_en = 1'b1; cmd_o.rsel = pl0_pkg::RaTopM2;
              state_d = SRd2;
            end
          end
        endcase
      end
      SRd2: begin
        if (fn == pl0_pkg::FnOpr && arg == pl0_pkg::OpRet) begin
          cmd_o.ret_pc = 1'b1;
          state_d = SAlu;
          ph_d = 2'd3;
        end else begin
          cmd_o.cap_x = 1'b1;
          state_d = SAlu;
          ph_d = 2'd0;
        end
      end
      SAlu: begin
        if (ph_q == 2'd3) begin
          // return is complete, base and pc already restored
          state_d = SFin;
        end else if (ph_q == 2'd0) begin
          cmd_o.alu_start = 1'b1;
          ph_d = 2'd1;
        end else if (stat_i.alu_done) begin
          cmd_o.wr_en = 1'b1;
          cmd_o.dsel  = pl0_pkg::WdAlu;
          if (arg == pl0_pkg::OpNeg) cmd_o.wsel = pl0_pkg::WaTopM1;
          else begin
            cmd_o.wsel = pl0_pkg::WaTopM2;
            cmd_o.top_dec = 1'b1;
            if (arg == pl0_pkg::OpDiv && stat_i.div0) st_d = pl0_pkg::StDiv0;
          end
          state_d = SFin;
        end
      end
      SFin: begin
        state_d = SOut;
      end
      SOut: begin
        res_d.next_pc     = pc_i;
        res_d.print_kind  = kind_q;
        res_d.print_value = pval_q;
        res_d.halted      = (pc_i == 10'd0);
        res_d.status      = st_q;
        out_v_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr;
      out_v_q <= 1'b0;
      hops_q  <= '0;
      ph_q    <= '0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
      hops_q  <= hops_d;
      ph_q    <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    st_q   <= st_d;
    pval_q <= pval_d;
    res_q  <= res_d;
  end

endmodule

>>> rtl/pl0_pcode_stack_machine.sv
// pl0_pcode_stack_machine: one p-code instruction per input beat, one result beat each
// each instruction first walks its link hops, then runs its own steps; a nonzero divide
//   waits on the serial divider
// throughput: one instruction at a time; the next beat is taken once the result beat has left
// reset: control clears at once, then the stack is zeroed before the first beat
// uses pl0_pkg, pl0_ctrl, pl0_dp
module pl0_pcode_stack_machine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pl0_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pl0_pkg::out_item_t out_data_o
);

  pl0_pkg::dp_cmd_t  cmd;
  pl0_pkg::dp_stat_t stat;
  logic [31:0] rdat;
  logic [9:0]  pc;

  pl0_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_level_i (in_data_i.op_level),
    .in_fn_i    (in_data_i.op_function),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_data_o),
    .cmd_o      (cmd),
    .stat_i     (stat),
    .rdat_i     (rdat),
    .pc_i       (pc)
  );

  pl0_dp u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_data_i),
    .cmd_i (cmd),
    .stat_o(stat),
    .rdat_o(rdat),
    .pc_o  (pc)
  );

endmodule

>>> tb/pl0_checker.sv
// pl0_checker: watches both channels of the p-code stack machine, predicts each result beat
// from its own copy of stack, top, base and pc, and counts mismatches; depends on pl0_pkg
`timescale 1ns / 100ps
module pl0_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  pl0_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  pl0_pkg::out_item_t out_data_i,
  output int                 errors_o,
  output int                 pending_o
);

  logic [31:0]              stk_mem [pl0_pkg::StackDepth];
  logic [pl0_pkg::TopW-1:0] sp;
  logic [pl0_pkg::PcW-1:0]  fb;
  logic [pl0_pkg::PcW-1:0]  pc;
  pl0_pkg::out_item_t       result_q[$];

  function automatic logic [pl0_pkg::PcW-1:0] link_walk(logic [3:0] hops);
    logic [pl0_pkg::PcW-1:0] b;
    int n;
    b = fb;
    n = (hops > pl0_pkg::MaxLevel) ? pl0_pkg::MaxLevel : hops;
    for (int i = 0; i < n; i++) b = stk_mem[b][pl0_pkg::PcW-1:0];
    return b;
  endfunction

  function automatic pl0_pkg::out_item_t exec_instr(pl0_pkg::in_item_t ins);
    pl0_pkg::out_item_t r;
    logic [31:0] arg, x, y, v;
    logic [9:0]  ad;
    longint      nt;
    int          t;
    r = '0;
    arg = ins.op_argument;
    t = sp;
    r.status = pl0_pkg::StOk;
    pc = pc + 1'b1;
    case (ins.op_function)
      pl0_pkg::FnLit, pl0_pkg::FnLod: begin
        if (t >= pl0_pkg::StackDepth) r.status = pl0_pkg::StStack;
        else begin
          v = arg;
          if (ins.op_function == pl0_pkg::FnLod) begin
            ad = arg + link_walk(ins.op_level);
            v = stk_mem[ad];
          end
          stk_mem[t] = v;
          sp = t + 1;
        end
      end
      pl0_pkg::FnSto: begin
        if (t == 0 || t > pl0_pkg::StackDepth) r.status = pl0_pkg::StStack;
        else begin
          sp = t - 1;
          ad = arg + link_walk(ins.op_level);
          stk_mem[ad] = stk_mem[t-1];
        end
      end
      pl0_pkg::FnCal: begin
        if (t + 2 >= pl0_pkg::StackDepth) r.status = pl0_pkg::StStack;
        else begin
          stk_mem[t]   = link_walk(ins.op_level);
          stk_mem[t+1] = fb;
          stk_mem[t+2] = pc;
          fb = t;
          pc = arg[pl0_pkg::PcW-1:0];
        end
      end
      pl0_pkg::FnInt: begin
        nt = longint'(t) + longint'($signed(arg));
        if (nt < 0 || nt > pl0_pkg::StackDepth) r.status = pl0_pkg::StStack;
        else sp = nt;
      end
      pl0_pkg::FnJmp: pc = arg[pl0_pkg::PcW-1:0];
      pl0_pkg::FnJpc: begin
        if (t == 0 || t > pl0_pkg::StackDepth) r.status = pl0_pkg::StStack;
        else if (stk_mem[t-1] == 0) pc = arg[pl0_pkg::PcW-1:0];
      end
      default: begin
        if (arg == pl0_pkg::OpRet) begin
          sp = fb;
          pc = stk_mem[fb + 10'd2][pl0_pkg::PcW-1:0];
          fb = stk_mem[fb + 10'd1][pl0_pkg::PcW-1:0];
        end else if (arg == pl0_pkg::OpNeg || arg == pl0_pkg::OpWrt) begin
          if (t == 0 || t > pl0_pkg::StackDepth) r.status = pl0_pkg::StStack;
          else if (arg == pl0_pkg::OpNeg) stk_mem[t-1] = -stk_mem[t-1];
          else begin
            r.print_kind  = pl0_pkg::PkValue;
            r.print_value = stk_mem[t-1];
          end
        end else if (arg >= pl0_pkg::OpAdd && arg <= pl0_pkg::OpLe) begin
          if (t < 2 || t > pl0_pkg::StackDepth) r.status = pl0_pkg::StStack;
          else begin
            x = stk_mem[t-2];
            y = stk_mem[t-1];
            case (arg)
              pl0_pkg::OpAdd: v = x + y;
              pl0_pkg::OpSub: v = x - y;
              pl0_pkg::OpMul: v = x * y;
              pl0_pkg::OpDiv: begin
                if (y == 0) begin
                  v = 0;
                  r.status = pl0_pkg::StDiv0;
                end else if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF) v = x;
                else v = $signed(x) / $signed(y);
              end
              pl0_pkg::OpEq: v = (x == y);
              pl0_pkg::OpNe: v = (x != y);
              pl0_pkg::OpLt: v = ($signed(x) < $signed(y));
              pl0_pkg::OpGe: v = ($signed(x) >= $signed(y));
              pl0_pkg::OpGt: v = ($signed(x) > $signed(y));
              default: v = ($signed(x) <= $signed(y));
            endcase
            sp = t - 1;
            stk_mem[t-2] = v;
          end
        end else if (arg == pl0_pkg::OpNl) r.print_kind = pl0_pkg::PkNl;
        else if (arg == pl0_pkg::OpRd) begin
          if (t >= pl0_pkg::StackDepth) r.status = pl0_pkg::StStack;
          else begin
            stk_mem[t] = ins.read_value;
            sp = t + 1;
          end
        end else r.status = pl0_pkg::StBadOp;
      end
    endcase
    r.next_pc = pc;
    r.halted  = (pc == 0);
    return r;
  endfunction

  assign pending_o = result_q.size();

  initial begin
    errors_o = 0;
    sp = '0;
    fb = '0;
    pc = '0;
    for (int i = 0; i < pl0_pkg::StackDepth; i++) stk_mem[i] = '0;
  end

  always @(posedge clk_i) begin
    pl0_pkg::out_item_t e;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $realtime, out_data_i);
          errors_o++;
        end else begin
          e = result_q.pop_front();
          if (e.next_pc !== out_data_i.next_pc)
            $display("%0t: next_pc exp %0d got %0d", $realtime, e.next_pc, out_data_i.next_pc);
          if (e.print_kind !== out_data_i.print_kind)
            $display("%0t: print_kind exp %0d got %0d", $realtime, e.print_kind,
                     out_data_i.print_kind);
          if (e.print_value !== out_data_i.print_value)
            $display("%0t: print_value exp %h got %h", $realtime, e.print_value,
                     out_data_i.print_value);
          if (e.halted !== out_data_i.halted)
            $display("%0t: halted exp %0d got %0d", $realtime, e.halted, out_data_i.halted);
          if (e.status !== out_data_i.status)
            $display("%0t: status exp %0d got %0d", $realtime, e.status, out_data_i.status);
          if (e !== out_data_i) errors_o++;
        end
      end
      if (in_valid_i && in_ready_i) result_q.push_back(exec_instr(in_data_i));
    end
  end
endmodule

>>> tb/tb_top.sv
// tb_top: drives random and directed p-code instructions into pl0_pcode_stack_machine
// with bursty input and stalling output; depends on pl0_pkg and pl0_checker
`timescale 1ns / 100ps
module tb_top;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  pl0_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  pl0_pkg::out_item_t out_data_o;
  int                 errors, pending;
  int                 burst_left = 0;
  bit                 long_hold_done = 0;

  always #5 clk_i = ~clk_i;

  pl0_pcode_stack_machine DUT (.*);

  pl0_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .errors_o(errors), .pending_o(pending)
  );

  function automatic pl0_pkg::in_item_t instr(logic [2:0] f, logic [3:0] l, logic [31:0] a,
                                              logic [31:0] rd = 0);
    pl0_pkg::in_item_t it;
    it.op_function = f;
    it.op_level    = l;
    it.op_argument = a;
    it.read_value  = rd;
    return it;
  endfunction

  function automatic pl0_pkg::in_item_t rand_instr();
    int w;
    logic [31:0] a;
    logic [2:0] f;
    w = $urandom_range(99);
    if (w < 20) f = pl0_pkg::FnLit;
    else if (w < 30) f = pl0_pkg::FnLod;
    else if (w < 40) f = pl0_pkg::FnSto;
    else if (w < 45) f = pl0_pkg::FnCal;
    else if (w < 53) f = pl0_pkg::FnInt;
    else if (w < 58) f = pl0_pkg::FnJmp;
    else if (w < 65) f = pl0_pkg::FnJpc;
    else f = pl0_pkg::FnOpr;
    w = $urandom_range(99);
    case (f)
      pl0_pkg::FnLit:   a = (w < 40) ? $urandom : $urandom_range(10) - 5;
      pl0_pkg::FnLod, pl0_pkg::FnSto: a = (w < 10) ? $urandom : $urandom_range(15);
      pl0_pkg::FnInt: begin
        if (w < 5) a = $urandom_range(1030, 990);
        else if (w < 8) a = -$urandom_range(1100, 900);
        else if (w < 10) a = $urandom;
        else a = $urandom_range(9) - 3;
      end
      pl0_pkg::FnOpr: begin
        if (w < 3) a = $urandom;
        else if (w < 8) a = $urandom_range(31, 15);
        else a = $urandom_range(14);
      end
      default: a = (w < 20) ? $urandom : $urandom_range(pl0_pkg::CodeDepth - 1);
    endcase
    return instr(f, ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(3),
                 a, $urandom);
  endfunction

  task automatic send(pl0_pkg::in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left > 0) burst_left--;
    else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6)) @(posedge clk_i);
      burst_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
    end
  endtask

  // receiver: random stalls, at most one long hold-off while the sender keeps offering beats
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && u_checker.pending_o > 0 && $urandom_range(300) == 0) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold_done = 1;
      end else if ($urandom_range(3) == 0) out_ready_i <= 1'b0;
      else out_ready_i <= 1'b1;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, each function code, neg, div, wrt, nl, rd, ret and the fault cases
    send(instr(pl0_pkg::FnLit, 0, 32'h7FFF_FFFF));
    send(instr(pl0_pkg::FnLit, 0, 32'h8000_0000));
    send(instr(pl0_pkg::FnOpr, 0, pl0_pkg::OpNeg));
    send(instr(pl0_pkg::FnLit, 0, 32'h8000_0000));
    send(instr(pl0_pkg::FnLit, 0, 32'hFFFF_FFFF));
    send(instr(pl0_pkg::FnOpr, 0, pl0_pkg::OpDiv));
    send(instr(pl0_pkg::FnLit, 0, 0));
    send(instr(pl0_pkg::FnOpr, 0, pl0_pkg::OpDiv));
    send(instr(pl0_pkg::FnOpr, 0, pl0_pkg::OpWrt));
    send(instr(pl0_pkg::FnOpr, 0, pl0_pkg::OpNl));
    send(instr(pl0_pkg::FnOpr, 0, pl0_pkg::OpRd, 32'hFFFF_FFFF));
    send(instr(pl0_pkg::FnOpr, 0, 32'd15));
    send(instr(pl0_pkg::FnOpr, 0, 32'hFFFF_FFFF));
    send(instr(pl0_pkg::FnLod, 15, 32'hFFFF_FFFF));
    send(instr(pl0_pkg::FnSto, 15, 32'h8000_0000));
    send(instr(pl0_pkg::FnCal, 3, 32'd1023));
    send(instr(pl0_pkg::FnJpc, 0, 32'd7));
    send(instr(pl0_pkg::FnOpr, 0, pl0_pkg::OpRet));
    send(instr(pl0_pkg::FnInt, 0, 32'd2000));
    send(instr(pl0_pkg::FnInt, 0, -32'sd5000));
    send(instr(pl0_pkg::FnInt, 0, 32'd1024));
    send(instr(pl0_pkg::FnJmp, 0, 32'hFFFF_FC00));
    for (int i = 0; i < 1850; i++) send(rand_instr());
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  initial begin
    #10ms;
    $display("tb_top failed");
    $finish;
  end
endmodule

>>> sim.f
rtl/pl0_pkg.sv
rtl/pl0_alu.sv
rtl/pl0_dp.sv
rtl/pl0_ctrl.sv
rtl/pl0_pcode_stack_machine.sv
tb/pl0_checker.sv
tb/tb_top.sv
